### rtl/core/pgvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgvs_pkg
// Shared types, widths and helpers for the per-group value statistics unit.
// ----------------------------------------------------------------------------
package pgvs_pkg;

  localparam int MAX_GROUPS = 16;
  localparam int MAX_ATOMS  = 1024;
  localparam int GRP_AW     = $clog2(MAX_GROUPS);
  localparam int GRP_CW     = $clog2(MAX_GROUPS + 1);
  localparam int ATOM_AW    = $clog2(MAX_ATOMS);
  localparam int ATOM_CW    = $clog2(MAX_ATOMS + 1);

  localparam int CODE_W = 16;
  localparam int VAL_W  = 18;
  localparam int CNT_W  = 11;
  localparam int SUM_W  = 28;
  localparam int SQ_W   = 45;
  localparam int MED_W  = 19;
  localparam int RMS_W  = 17;
  localparam int ENT_W  = GRP_AW + VAL_W;

  localparam int DIV_W  = 45;
  localparam int DVS_W  = 12;
  localparam int RT_W   = 23;

  localparam int BIS_STEPS = VAL_W;
  localparam int ITER_W    = $clog2(BIS_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_UPD,
    S_GSTART,
    S_DIVM,
    S_DIVQ,
    S_SQRT,
    S_SCAN,
    S_OUT
  } state_t;

  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    fold_byte = (b >= LOWER_A && b <= LOWER_Z) ? b - CASE_OFS : b;
  endfunction

  function automatic logic [CODE_W-1:0] fold_code(input logic [CODE_W-1:0] c);
    fold_code = {fold_byte(c[15:8]), fold_byte(c[7:0])};
  endfunction

endpackage
`default_nettype wire

### rtl/core/pgvs_atom_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgvs_atom_if
// Atom request channel: element code, B-factor and end-of-set mark.
// ----------------------------------------------------------------------------
interface pgvs_atom_if;
  logic                                    valid;
  logic                                    ready;
  logic [pgvs_pkg::CODE_W-1:0]             element_code;
  logic signed [pgvs_pkg::VAL_W-1:0]       b_value;
  logic                                    last_atom;

  modport source(output valid, element_code, b_value, last_atom, input ready);
  modport sink(input valid, element_code, b_value, last_atom, output ready);
endinterface
`default_nettype wire

### rtl/core/pgvs_group_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgvs_group_if
// Group result channel: one request per group at the end of a set.
// ----------------------------------------------------------------------------
interface pgvs_group_if;
  logic                                valid;
  logic                                ready;
  logic [pgvs_pkg::CODE_W-1:0]         group_element;
  logic [pgvs_pkg::CNT_W-1:0]          group_size;
  logic signed [pgvs_pkg::VAL_W-1:0]   min_value;
  logic signed [pgvs_pkg::VAL_W-1:0]   max_value;
  logic signed [pgvs_pkg::VAL_W-1:0]   mean_value;
  logic signed [pgvs_pkg::MED_W-1:0]   median_doubled;
  logic [pgvs_pkg::RMS_W-1:0]          rms_value;
  logic                                overflow;
  logic                                last_group;

  modport source(output valid, group_element, group_size, min_value, max_value,
                 mean_value, median_doubled, rms_value, overflow, last_group,
                 input ready);
  modport sink(input valid, group_element, group_size, min_value, max_value,
               mean_value, median_doubled, rms_value, overflow, last_group,
               output ready);
endinterface
`default_nettype wire

### rtl/core/pgvs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgvs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgvs_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pgvs_pkg::DIV_W-1:0]    dividend,
  input  wire logic [pgvs_pkg::DVS_W-1:0]    divisor,
  output logic                               done,
  output logic [pgvs_pkg::DIV_W-1:0]         quotient
);
  localparam int CW = $clog2(pgvs_pkg::DIV_W);

  logic                         busy;
  logic [CW-1:0]                step;
  logic [pgvs_pkg::DVS_W-1:0]   rem;
  logic [pgvs_pkg::DVS_W-1:0]   dvs;
  logic [pgvs_pkg::DVS_W:0]     trial;
  logic                         fits;

  assign trial = {rem, quotient[pgvs_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == CW'(pgvs_pkg::DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      step     <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (fits) begin
        rem      <= pgvs_pkg::DVS_W'(trial - {1'b0, dvs});
        quotient <= {quotient[pgvs_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[pgvs_pkg::DVS_W-1:0];
        quotient <= {quotient[pgvs_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/pgvs_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgvs_isqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pgvs_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pgvs_pkg::DIV_W-1:0]    radicand,
  output logic                               done,
  output logic [pgvs_pkg::RT_W-1:0]          root
);
  localparam int SW = 2 * pgvs_pkg::RT_W;
  localparam int RW = pgvs_pkg::RT_W + 2;
  localparam int CW = $clog2(pgvs_pkg::RT_W);

  logic            busy;
  logic [CW-1:0]   step;
  logic [SW-1:0]   src;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   rem_s;
  logic [RW-1:0]   trial;

  assign rem_s = {rem[RW-3:0], src[SW-1:SW-2]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == CW'(pgvs_pkg::RT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= SW'(radicand);
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      src  <= {src[SW-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem  <= rem_s - trial;
        root <= {root[pgvs_pkg::RT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_s;
        root <= {root[pgvs_pkg::RT_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/per_group_value_statistics_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_group_value_statistics_unit
// Groups atoms by element code and reports count, min, max, mean, median and
// rms per group once the last atom of a set has arrived.
// ----------------------------------------------------------------------------
// Intake: an atom passes through the accept, group lookup and update states;
//   ready is low during lookup and update, and until the set's results are out.
// Results: per group the divider runs twice (mean, then mean square), then
//   the root unit, then 18 bisection passes over the store.
// Reset: synchronous, active high; clears group and atom counts and the
//   overflow flag. The stores are never cleared, so no clearing pass is run.
// ----------------------------------------------------------------------------
module per_group_value_statistics_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  pgvs_atom_if.sink          atoms,
  pgvs_group_if.source       results
);

  pgvs_pkg::state_t state, state_next;

  // Atom being taken in.
  logic [pgvs_pkg::CODE_W-1:0]      cur_code;
  logic signed [pgvs_pkg::VAL_W-1:0] cur_val;
  logic signed [2*pgvs_pkg::VAL_W-1:0] val_wide;
  logic                             cur_last;
  logic [2*pgvs_pkg::VAL_W-1:0]     sq;
  logic [pgvs_pkg::GRP_AW-1:0]      sel;
  logic                             sel_new;
  logic                             take;

  // Group register file; codes are compared in parallel, other fields read at one address.
  logic [pgvs_pkg::CODE_W-1:0]       codes [pgvs_pkg::MAX_GROUPS];
  logic [pgvs_pkg::CNT_W-1:0]        cnts  [pgvs_pkg::MAX_GROUPS];
  logic signed [pgvs_pkg::VAL_W-1:0] mins  [pgvs_pkg::MAX_GROUPS];
  logic signed [pgvs_pkg::VAL_W-1:0] maxs  [pgvs_pkg::MAX_GROUPS];
  logic signed [pgvs_pkg::SUM_W-1:0] sums  [pgvs_pkg::MAX_GROUPS];
  logic [pgvs_pkg::SQ_W-1:0]         sqs   [pgvs_pkg::MAX_GROUPS];

  logic [pgvs_pkg::GRP_CW-1:0]  groups_used;
  logic [pgvs_pkg::ATOM_CW-1:0] atoms_stored;
  logic                         overflow_seen;

  // Value store: group index and value of every kept atom.
  logic [pgvs_pkg::ENT_W-1:0] store_mem [pgvs_pkg::MAX_ATOMS];
  logic [pgvs_pkg::ENT_W-1:0] rd_data;

  logic [pgvs_pkg::GRP_AW-1:0] gi;
  logic [pgvs_pkg::GRP_AW-1:0] addr;
  logic                        last_grp;

  // Lookup results.
  logic                        found;
  logic [pgvs_pkg::GRP_AW-1:0] found_idx;

  // Divider, shared by mean and mean square, and root unit.
  logic                        div_start;
  logic                        div_done;
  logic [pgvs_pkg::DIV_W-1:0]  div_a;
  logic [pgvs_pkg::DVS_W-1:0]  div_b;
  logic [pgvs_pkg::DIV_W-1:0]  div_q;
  logic                        rt_start;
  logic                        rt_done;
  logic [pgvs_pkg::RT_W-1:0]   rt_root;

  logic [pgvs_pkg::SUM_W-1:0]  mag;
  logic                        mean_neg;
  logic signed [pgvs_pkg::VAL_W-1:0] mean;
  logic [pgvs_pkg::RMS_W-1:0]  rms;

  // Median bisection: two ranks searched at once.
  logic signed [pgvs_pkg::VAL_W-1:0] lo1, hi1, lo2, hi2;
  logic signed [pgvs_pkg::VAL_W:0]   s1, s2;
  logic signed [pgvs_pkg::VAL_W-1:0] mid1, mid2;
  logic [pgvs_pkg::CNT_W-1:0]        c1, c2, k1, k2;
  logic [pgvs_pkg::ATOM_CW-1:0]      rd_addr;
  logic                              rd_valid;
  logic                              issue;
  logic                              pass_done;
  logic [pgvs_pkg::ITER_W-1:0]       iter;
  logic signed [pgvs_pkg::VAL_W-1:0] rd_val;
  logic [pgvs_pkg::GRP_AW-1:0]       rd_grp;

  assign addr     = (state == pgvs_pkg::S_UPD) ? sel : gi;
  assign last_grp = (pgvs_pkg::GRP_CW'(gi) + 1'b1) == groups_used;

  // Parallel compare against every group in use; lowest match wins.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int g = pgvs_pkg::MAX_GROUPS - 1; g >= 0; g--) begin
      if (pgvs_pkg::GRP_CW'(g) < groups_used && codes[g] == cur_code) begin
        found     = 1'b1;
        found_idx = pgvs_pkg::GRP_AW'(g);
      end
    end
  end

  assign mag = sums[addr][pgvs_pkg::SUM_W-1] ? pgvs_pkg::SUM_W'(-sums[addr])
                                             : pgvs_pkg::SUM_W'(sums[addr]);

  always_comb begin
    if (state == pgvs_pkg::S_GSTART) begin
      div_a = pgvs_pkg::DIV_W'({mag, 1'b0}) + pgvs_pkg::DIV_W'(cnts[addr]);
      div_b = {cnts[addr], 1'b0};
    end else begin
      div_a = pgvs_pkg::DIV_W'(sqs[addr]);
      div_b = {1'b0, cnts[addr]};
    end
  end

  pgvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  pgvs_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (div_q),
    .done     (rt_done),
    .root     (rt_root)
  );

  assign s1   = (pgvs_pkg::VAL_W + 1)'(lo1) + (pgvs_pkg::VAL_W + 1)'(hi1);
  assign s2   = (pgvs_pkg::VAL_W + 1)'(lo2) + (pgvs_pkg::VAL_W + 1)'(hi2);
  assign mid1 = s1[pgvs_pkg::VAL_W:1];
  assign mid2 = s2[pgvs_pkg::VAL_W:1];
  assign k1   = (cnts[addr] - 1'b1) >> 1;
  assign k2   = cnts[addr] >> 1;
  assign {rd_grp, rd_val} = rd_data;
  assign issue     = rd_addr < atoms_stored;
  assign pass_done = !issue && !rd_valid;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pgvs_pkg::S_IDLE:   if (atoms.valid) state_next = pgvs_pkg::S_FIND;
      pgvs_pkg::S_FIND:   state_next = pgvs_pkg::S_UPD;
      pgvs_pkg::S_UPD:    state_next = cur_last ? pgvs_pkg::S_GSTART : pgvs_pkg::S_IDLE;
      pgvs_pkg::S_GSTART: begin
        state_next = (groups_used == '0) ? pgvs_pkg::S_IDLE : pgvs_pkg::S_DIVM;
      end
      pgvs_pkg::S_DIVM:   if (div_done) state_next = pgvs_pkg::S_DIVQ;
      pgvs_pkg::S_DIVQ:   if (div_done) state_next = pgvs_pkg::S_SQRT;
      pgvs_pkg::S_SQRT:   if (rt_done) state_next = pgvs_pkg::S_SCAN;
      pgvs_pkg::S_SCAN: begin
        if (pass_done && iter == pgvs_pkg::ITER_W'(pgvs_pkg::BIS_STEPS - 1)) begin
          state_next = pgvs_pkg::S_OUT;
        end
      end
      pgvs_pkg::S_OUT: begin
        if (results.ready) state_next = last_grp ? pgvs_pkg::S_IDLE : pgvs_pkg::S_GSTART;
      end
      default:            state_next = pgvs_pkg::S_IDLE;
    endcase
  end

  // Handshake and unit strobes.
  always_comb begin
    atoms.ready   = 1'b0;
    results.valid = 1'b0;
    div_start     = 1'b0;
    rt_start      = 1'b0;
    case (state)
      pgvs_pkg::S_IDLE:   atoms.ready = 1'b1;
      pgvs_pkg::S_GSTART: div_start = (groups_used != '0);
      pgvs_pkg::S_DIVM:   div_start = div_done;
      pgvs_pkg::S_DIVQ:   rt_start = div_done;
      pgvs_pkg::S_OUT:    results.valid = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgvs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Run control: group and atom counts, overflow, current output group.
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_used   <= '0;
      atoms_stored  <= '0;
      overflow_seen <= 1'b0;
      gi            <= '0;
    end else begin
      case (state)
        pgvs_pkg::S_FIND: begin
          if (!take) overflow_seen <= 1'b1;
        end
        pgvs_pkg::S_UPD: begin
          gi <= '0;
          if (take) begin
            atoms_stored <= atoms_stored + 1'b1;
            if (sel_new) groups_used <= groups_used + 1'b1;
          end
        end
        pgvs_pkg::S_GSTART: begin
          if (groups_used == '0) begin
            atoms_stored  <= '0;
            overflow_seen <= 1'b0;
          end
        end
        pgvs_pkg::S_OUT: begin
          if (results.ready) begin
            gi <= gi + 1'b1;
            if (last_grp) begin
              groups_used   <= '0;
              atoms_stored  <= '0;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sign-extend before squaring so the full product is kept.
  assign val_wide = (2*pgvs_pkg::VAL_W)'(cur_val);

  // Latch the atom, square it, decide its group.
  always_ff @(posedge clk) begin
    if (state == pgvs_pkg::S_IDLE && atoms.valid) begin
      cur_code <= pgvs_pkg::fold_code(atoms.element_code);
      cur_val  <= atoms.b_value;
      cur_last <= atoms.last_atom;
    end
    if (state == pgvs_pkg::S_FIND) begin
      sq      <= val_wide * val_wide;
      sel     <= found ? found_idx : groups_used[pgvs_pkg::GRP_AW-1:0];
      sel_new <= !found;
    end
  end

  always_comb begin
    take = (atoms_stored < pgvs_pkg::ATOM_CW'(pgvs_pkg::MAX_ATOMS)) &&
           (found || groups_used < pgvs_pkg::GRP_CW'(pgvs_pkg::MAX_GROUPS));
  end

  logic take_q;
  always_ff @(posedge clk) begin
    if (state == pgvs_pkg::S_FIND) take_q <= take;
  end

  // Group register file update.
  always_ff @(posedge clk) begin
    if (state == pgvs_pkg::S_UPD && take_q) begin
      if (sel_new) begin
        codes[sel] <= cur_code;
        cnts[sel]  <= pgvs_pkg::CNT_W'(1);
        mins[sel]  <= cur_val;
        maxs[sel]  <= cur_val;
        sums[sel]  <= pgvs_pkg::SUM_W'(cur_val);
        sqs[sel]   <= pgvs_pkg::SQ_W'(sq);
      end else begin
        cnts[sel] <= cnts[sel] + 1'b1;
        if (cur_val < mins[sel]) mins[sel] <= cur_val;
        if (cur_val > maxs[sel]) maxs[sel] <= cur_val;
        sums[sel] <= sums[sel] + pgvs_pkg::SUM_W'(cur_val);
        sqs[sel]  <= sqs[sel] + pgvs_pkg::SQ_W'(sq);
      end
    end
  end

  // Value store: written once per kept atom, read once per scan cycle.
  always_ff @(posedge clk) begin
    if (state == pgvs_pkg::S_UPD && take_q) begin
      store_mem[atoms_stored[pgvs_pkg::ATOM_AW-1:0]] <= {sel, cur_val};
    end
    rd_data <= store_mem[rd_addr[pgvs_pkg::ATOM_AW-1:0]];
  end

  // Mean and rms capture.
  always_ff @(posedge clk) begin
    if (state == pgvs_pkg::S_GSTART) mean_neg <= sums[addr][pgvs_pkg::SUM_W-1];
    if (state == pgvs_pkg::S_DIVM && div_done) begin
      mean <= mean_neg ? -pgvs_pkg::VAL_W'(div_q) : pgvs_pkg::VAL_W'(div_q);
    end
    if (state == pgvs_pkg::S_SQRT && rt_done) begin
      rms <= (rt_root > pgvs_pkg::RT_W'({pgvs_pkg::RMS_W{1'b1}})) ?
             {pgvs_pkg::RMS_W{1'b1}} : rt_root[pgvs_pkg::RMS_W-1:0];
    end
  end

  // Median search: narrow both rank windows once per pass over the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == pgvs_pkg::S_SCAN) && issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pgvs_pkg::S_GSTART) begin
      lo1     <= {1'b1, {(pgvs_pkg::VAL_W-1){1'b0}}};
      hi1     <= {1'b0, {(pgvs_pkg::VAL_W-1){1'b1}}};
      lo2     <= {1'b1, {(pgvs_pkg::VAL_W-1){1'b0}}};
      hi2     <= {1'b0, {(pgvs_pkg::VAL_W-1){1'b1}}};
      rd_addr <= '0;
      c1      <= '0;
      c2      <= '0;
      iter    <= '0;
    end else if (state == pgvs_pkg::S_SCAN) begin
      if (issue) rd_addr <= rd_addr + 1'b1;
      if (rd_valid && rd_grp == gi) begin
        if (rd_val <= mid1) c1 <= c1 + 1'b1;
        if (rd_val <= mid2) c2 <= c2 + 1'b1;
      end
      if (pass_done) begin
        if (c1 > k1) hi1 <= mid1; else lo1 <= mid1 + 1'b1;
        if (c2 > k2) hi2 <= mid2; else lo2 <= mid2 + 1'b1;
        rd_addr <= '0;
        c1      <= '0;
        c2      <= '0;
        iter    <= iter + 1'b1;
      end
    end
  end

  assign results.group_element  = codes[addr];
  assign results.group_size     = cnts[addr];
  assign results.min_value      = mins[addr];
  assign results.max_value      = maxs[addr];
  assign results.mean_value     = mean;
  assign results.median_doubled = pgvs_pkg::MED_W'(lo1) + pgvs_pkg::MED_W'(lo2);
  assign results.rms_value      = rms;
  assign results.overflow       = overflow_seen;
  assign results.last_group     = last_grp;

endmodule
`default_nettype wire

### rtl/core/pgvs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgvs_checker
// Port-level checks on the statistics unit, attached by bind.
// ----------------------------------------------------------------------------
module pgvs_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [pgvs_pkg::CNT_W-1:0]         out_size,
  input wire logic signed [pgvs_pkg::VAL_W-1:0]  out_min,
  input wire logic signed [pgvs_pkg::VAL_W-1:0]  out_max,
  input wire logic signed [pgvs_pkg::MED_W-1:0]  out_med
);
  logic signed [pgvs_pkg::MED_W:0] min2, max2;

  assign min2 = {out_min[pgvs_pkg::VAL_W-1], out_min, 1'b0};
  assign max2 = {out_max[pgvs_pkg::VAL_W-1], out_max, 1'b0};

  // Results are only shown while no atom can be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("result shown while accepting atoms");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_min) && $stable(out_med))
    else $error("stalled result changed");

  a_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_size != '0) else $error("empty group reported");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_min <= out_max) else $error("min above max");

  a_median: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min2 <= out_med) && (out_med <= max2))
    else $error("median outside group range");
endmodule

bind per_group_value_statistics_unit pgvs_checker u_pgvs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (atoms.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_size  (results.group_size),
  .out_min   (results.min_value),
  .out_max   (results.max_value),
  .out_med   (results.median_doubled)
);
`default_nettype wire

### tb/per_group_value_statistics_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_group_value_statistics_unit_tb
// Streams sets of atoms into the statistics unit and checks every group result
// against a predictor that keeps each set's values per group and computes
// count, min, max, rounded mean, doubled median and floor rms on its own.
// Covers case folding, value extremes, group capacity overflow,
// random sets, random idling on both sides and a long result-side hold-off.
// ----------------------------------------------------------------------------
module per_group_value_statistics_unit_tb;

  localparam int SETTLE_CYCLES = 400;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [pgvs_pkg::CODE_W-1:0]       element;
    logic [pgvs_pkg::CNT_W-1:0]        size;
    logic signed [pgvs_pkg::VAL_W-1:0] min_v;
    logic signed [pgvs_pkg::VAL_W-1:0] max_v;
    logic signed [pgvs_pkg::VAL_W-1:0] mean_v;
    logic signed [pgvs_pkg::MED_W-1:0] median2;
    logic [pgvs_pkg::RMS_W-1:0]        rms_v;
    logic                              ovf;
    logic                              last;
  } group_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pgvs_atom_if  atoms();
  pgvs_group_if results();

  per_group_value_statistics_unit dut (
    .clk    (clk),
    .rst    (rst),
    .atoms  (atoms),
    .results(results)
  );

  always #1 clk = ~clk;

  // Predictor state for the set in flight.
  logic [pgvs_pkg::CODE_W-1:0] set_codes [pgvs_pkg::MAX_GROUPS];
  int                set_values[pgvs_pkg::MAX_GROUPS][$];
  int                set_groups;
  int                set_atoms;
  bit                set_overflow;

  group_stats_t pending_stats[$];
  int           mismatches;
  bit           quiet;            // no idling on either side
  int           hold_off_cycles;  // long receiver hold-off, taken by the ready process

  // Floor square root, one result bit per pass from the top down.
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic logic [pgvs_pkg::CODE_W-1:0] upper_code(
      input logic [pgvs_pkg::CODE_W-1:0] c);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = c[15:8];
    lo = c[7:0];
    if (hi >= "a" && hi <= "z") hi = hi - 8'd32;
    if (lo >= "a" && lo <= "z") lo = lo - 8'd32;
    return {hi, lo};
  endfunction

  // Build one group's result from its stored values.
  function automatic group_stats_t group_summary(input int g, input bit final_group);
    group_stats_t    s;
    int              sorted[$];
    int              v;
    int              j;
    int              n;
    longint          total;
    longint unsigned squares;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned root;
    longint          med;
    n       = set_values[g].size();
    total   = 0;
    squares = 0;
    s.min_v = pgvs_pkg::VAL_W'(set_values[g][0]);
    s.max_v = pgvs_pkg::VAL_W'(set_values[g][0]);
    foreach (set_values[g][i]) begin
      v = set_values[g][i];
      total   += v;
      squares += longint'(v) * longint'(v);
      if (v < s.min_v) s.min_v = pgvs_pkg::VAL_W'(v);
      if (v > s.max_v) s.max_v = pgvs_pkg::VAL_W'(v);
      // insertion into ascending order
      j = sorted.size();
      sorted.push_back(v);
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    mag = (total < 0) ? longint'(-total) : longint'(total);
    q   = (2 * mag + n) / (2 * n);
    s.mean_v = pgvs_pkg::VAL_W'((total < 0) ? -longint'(q) : longint'(q));
    if (n % 2 == 1) med = 2 * longint'(sorted[n/2]);
    else med = longint'(sorted[n/2-1]) + longint'(sorted[n/2]);
    s.median2 = pgvs_pkg::MED_W'(med);
    root = floor_sqrt(squares / n);
    s.rms_v   = (root > 131071) ? 17'h1FFFF : root[pgvs_pkg::RMS_W-1:0];
    s.element = set_codes[g];
    s.size    = pgvs_pkg::CNT_W'(n);
    s.ovf     = set_overflow;
    s.last    = final_group;
    return s;
  endfunction

  // Take one accepted atom into the predictor; close the set on the last one.
  function automatic void take_atom(input logic [pgvs_pkg::CODE_W-1:0] raw,
                                    input int val, input bit last);
    logic [pgvs_pkg::CODE_W-1:0] code;
    int idx;
    code = upper_code(raw);
    idx  = -1;
    for (int g = 0; g < set_groups; g++)
      if (set_codes[g] == code && idx < 0) idx = g;
    if (set_atoms >= pgvs_pkg::MAX_ATOMS) set_overflow = 1'b1;
    else if (idx < 0 && set_groups >= pgvs_pkg::MAX_GROUPS) set_overflow = 1'b1;
    else begin
      if (idx < 0) begin
        idx = set_groups++;
        set_codes[idx] = code;
        set_values[idx].delete();
      end
      set_values[idx].push_back(val);
      set_atoms++;
    end
    if (last) begin
      for (int g = 0; g < set_groups; g++)
        pending_stats.push_back(group_summary(g, g == set_groups - 1));
      set_groups   = 0;
      set_atoms    = 0;
      set_overflow = 1'b0;
    end
  endfunction

  // Offer one atom request and hold it until it is taken.
  task automatic send_atom(input logic [pgvs_pkg::CODE_W-1:0] code, input int val,
                           input bit last);
    logic [pgvs_pkg::VAL_W-1:0] raw;
    raw = val[pgvs_pkg::VAL_W-1:0];
    atoms.element_code <= code;
    atoms.b_value      <= raw;
    atoms.last_atom    <= last;
    atoms.valid        <= 1'b1;
    do @(posedge clk); while (!atoms.ready);
    take_atom(code, $signed(raw), last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      atoms.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has arrived.
  task automatic drain_results();
    atoms.valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [pgvs_pkg::CODE_W-1:0] random_code();
    logic [7:0] letters[6] = '{"C", "N", "O", "S", "F", "Z"};
    logic [7:0] hi;
    logic [7:0] lo;
    if ($urandom_range(0, 9) == 0) return pgvs_pkg::CODE_W'($urandom_range(0, 16'hFFFF));
    hi = letters[$urandom_range(0, 5)];
    lo = $urandom_range(0, 1) ? 8'h20 : letters[$urandom_range(0, 5)];
    if ($urandom_range(0, 1)) hi = hi | 8'h20;
    if ($urandom_range(0, 1) && lo != 8'h20) lo = lo | 8'h20;
    return {hi, lo};
  endfunction

  function automatic int random_value();
    logic [pgvs_pkg::VAL_W-1:0] raw;
    if ($urandom_range(0, 7) == 0) begin
      raw = pgvs_pkg::VAL_W'($urandom());
      return $signed(raw);
    end
    return int'($urandom_range(0, 109998)) - 9999;
  endfunction

  // Case folding, value extremes, rounding ties and medians of both parities.
  task automatic test_directed();
    send_atom("fe", 131071, 1'b0);
    send_atom("FE", -131072, 1'b0);
    send_atom("Fe", 0, 1'b0);
    send_atom("fE", -1, 1'b0);
    send_atom("c", 1, 1'b0);          // low byte is the letter, high byte is 0x00
    send_atom(16'h6061, 2, 1'b0);     // byte just below 'a' kept, 'a' folded
    send_atom(16'h7B7A, -3, 1'b0);    // byte just above 'z' kept, 'z' folded
    send_atom(16'hFFFF, 99999, 1'b0);
    send_atom(16'h0000, -9999, 1'b0);
    send_atom("C ", 1, 1'b0);
    send_atom("c ", 2, 1'b1);         // mean 1.5 rounds away from zero
    send_atom("N ", -1, 1'b0);
    send_atom("n ", -2, 1'b0);        // mean -1.5 rounds away from zero
    send_atom("O ", 5, 1'b0);
    send_atom("o ", -7, 1'b0);
    send_atom("O ", 100, 1'b1);       // odd count median
    send_atom("S ", -131072, 1'b0);
    send_atom("S ", -131072, 1'b1);   // rms saturates
    send_atom("Zn", 42, 1'b1);        // single atom set
    drain_results();
  endtask

  // More distinct elements than groups: the extra ones are dropped.
  task automatic test_group_capacity();
    for (int i = 0; i < pgvs_pkg::MAX_GROUPS + 4; i++)
      send_atom({8'h41 + i[7:0], 8'h20}, random_value(), 1'b0);
    send_atom("A ", random_value(), 1'b0);
    send_atom("Zz", random_value(), 1'b1);   // new element at capacity, dropped
    drain_results();
  endtask

  // Hold the result side off while the next set is already being offered.
  task automatic test_backpressure();
    for (int i = 0; i < 8; i++) send_atom(random_code(), random_value(), 1'b0);
    hold_off_cycles = 3000;
    send_atom(random_code(), random_value(), 1'b1);
    for (int i = 0; i < 10; i++) send_atom(random_code(), random_value(), i == 9);
    drain_results();
  endtask

  // Random sets of random size, drained at random points and at the end.
  task automatic test_random_sets(input int total);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) send_atom(random_code(), random_value(), i == len - 1);
      sent += len;
      if ($urandom_range(0, 3) == 0) drain_results();
    end
    drain_results();
  endtask

  // Result side ready: random bursts, a long hold on request, steady when quiet.
  initial begin
    results.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        results.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        results.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    group_stats_t got;
    group_stats_t want;
    if (!rst && results.valid && results.ready) begin
      got = '{results.group_element, results.group_size, results.min_value,
              results.max_value, results.mean_value, results.median_doubled,
              results.rms_value, results.overflow, results.last_group};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result %p", got);
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    atoms.valid        = 1'b0;
    atoms.element_code = '0;
    atoms.b_value      = '0;
    atoms.last_atom    = 1'b0;
    set_groups      = 0;
    set_atoms       = 0;
    set_overflow    = 1'b0;
    mismatches      = 0;
    quiet           = 1'b0;
    hold_off_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_group_capacity();
    test_backpressure();
    test_random_sets(120);
    quiet = 1'b1;
    test_random_sets(40);
    if (pending_stats.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
